// ===== rtl/sgi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgi_pkg
// Shared widths, codes and controller/datapath interface types for the
// servo group interpolator.
// ----------------------------------------------------------------------------
package sgi_pkg;

    localparam int ANGLE_W   = 8;
    localparam int PULSE_W   = 12;
    localparam int CHAN_W    = 4;
    localparam int TGT_W     = 10;
    localparam int STEP_W    = 8;
    localparam int FUNC_W    = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX     = 8'd180;
    localparam logic [ANGLE_W-1:0] ANGLE_RST     = 8'd90;
    localparam logic [PULSE_W-1:0] PULSE_MIN_RST = 12'd125;
    localparam logic [PULSE_W-1:0] PULSE_MAX_RST = 12'd575;

    // angle * |span| product, and its division by 180:
    // x / 180 == ((x >> 2) * RECIP_MUL) >> RECIP_SHIFT for every x below 2^20
    localparam int              PROD_W      = ANGLE_W + PULSE_W;
    localparam int              RECIP_W     = 19;
    localparam int              RECIP_SHIFT = 24;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 19'd372828;

    localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ARM  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX = 1'b1;

    typedef struct packed {
        logic load;
        logic set_wr;
        logic div_start;
        logic div_step;
        logic arm_wr;
        logic scan_clr;
        logic scan_inc;
        logic tick_upd;
        logic emit;
        logic tick_end;
    } t_sgi_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              chan_ok;
        logic              steps_zero;
        logic              any_armed;
        logic              cur_armed;
        logic              scan_last;
        logic              div_done;
        logic              out_free;
    } t_sgi_sts;

endpackage

// ===== rtl/servo_group_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_group_interpolator
// Multi-channel servo angle interpolator with PWM pulse-width output.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  --------  -------------------  ---------------------------------------------
//  request   i_valid / o_ready    i_func, i_channel, i_target, i_step_count
//  result    o_valid / i_ready    o_out_channel, o_angle, o_pulse_width, o_last
//  config    i_cfg_we (no wait)   i_cfg_idx, i_cfg_data
//
//  One request is in work at a time; o_ready is high only when it is done.
//  Set runs decode, store, two pulse-arithmetic stages and emit. Arm runs
//  the restoring divider that produces one increment bit per cycle. A tick
//  with steps left walks every channel through the single read port of the
//  channel RAM and the pulse multiplier chain for each armed channel. Reset
//  is synchronous and clears control state only; channel RAMs need no
//  clearing pass. A stalled result holds in the output register and the
//  sequencer holds at its emit step until that register frees up.
//
module servo_group_interpolator #(
    parameter int CHANNELS  = 16,
    parameter int FRAC_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [sgi_pkg::FUNC_W-1:0]       i_func,
    input  logic [sgi_pkg::CHAN_W-1:0]       i_channel,
    input  logic signed [sgi_pkg::TGT_W-1:0] i_target,
    input  logic [sgi_pkg::STEP_W-1:0]       i_step_count,
    // result channel
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [sgi_pkg::CHAN_W-1:0]       o_out_channel,
    output logic [sgi_pkg::ANGLE_W-1:0]      o_angle,
    output logic [sgi_pkg::PULSE_W-1:0]      o_pulse_width,
    output logic                             o_last,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [sgi_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sgi_pkg::PULSE_W-1:0]      i_cfg_data
);

    import sgi_pkg::*;

    logic [PULSE_W-1:0] r_pulse_min;
    logic [PULSE_W-1:0] r_pulse_max;
    logic [PULSE_W-1:0] r_span_mag;
    logic               r_span_neg;
    logic [PULSE_W:0]   span;

    t_sgi_cmd cmd;
    t_sgi_sts sts;

    // Pulse range registers; the user must write them only while idle (not enforced here).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_min <= PULSE_MIN_RST;
            r_pulse_max <= PULSE_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PULSE_MIN: r_pulse_min <= i_cfg_data;
                CFG_PULSE_MAX: r_pulse_max <= i_cfg_data;
                default:       r_pulse_min <= r_pulse_min;
            endcase
        end
    end

    // Hold the span as sign and magnitude so the pulse path multiplies
    // unsigned values and truncation toward zero falls out of the magnitude.
    assign span = {1'b0, r_pulse_max} - {1'b0, r_pulse_min};

    always_ff @(posedge i_clk) begin
        r_span_neg <= span[PULSE_W];
        r_span_mag <= span[PULSE_W] ? PULSE_W'(~span + 1'b1) : span[PULSE_W-1:0];
    end

    sgi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    sgi_dpath #(
        .CHANNELS  (CHANNELS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_func        (i_func),
        .i_channel     (i_channel),
        .i_target      (i_target),
        .i_step_count  (i_step_count),
        .i_pulse_min   (r_pulse_min),
        .i_span_mag    (r_span_mag),
        .i_span_neg    (r_span_neg),
        .i_out_ready   (i_ready),
        .o_out_valid   (o_valid),
        .o_out_channel (o_out_channel),
        .o_angle       (o_angle),
        .o_pulse_width (o_pulse_width),
        .o_last        (o_last)
    );

    // A channel is armed only while a move has steps left to run.
    a_armed_needs_steps: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        sts.steps_zero |-> !sts.any_armed
    ) else $error("channel armed with no steps left");

    // An accepted request makes the block busy in the next cycle.
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready
    ) else $error("request accepted while previous one still decoding");

    // A result is loaded only into a free output register.
    a_emit_into_free: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_valid || i_ready)
    ) else $error("result overwrote a pending result");

    // The divider never steps past its last quotient bit.
    a_div_bounded: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_step |-> !sts.div_done
    ) else $error("divider stepped after completion");

endmodule

// ===== rtl/sgi_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sgi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sgi_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgi_ctrl
// Sequencer for set, arm and tick requests; drives datapath commands.
// ----------------------------------------------------------------------------
module sgi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  sgi_pkg::t_sgi_sts i_sts,
    output sgi_pkg::t_sgi_cmd o_cmd
);

    import sgi_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_SET      = 4'd2;
    localparam logic [3:0] S_ARM_LD   = 4'd3;
    localparam logic [3:0] S_ARM_DIV  = 4'd4;
    localparam logic [3:0] S_TICK_RD  = 4'd5;
    localparam logic [3:0] S_TICK_UPD = 4'd6;
    localparam logic [3:0] S_PULSE1   = 4'd7;
    localparam logic [3:0] S_PULSE2   = 4'd8;
    localparam logic [3:0] S_EMIT     = 4'd9;
    localparam logic [3:0] S_TICK_END = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_sgi_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.func)
                    FUNC_SET: begin
                        n_state = i_sts.chan_ok ? S_SET : S_IDLE;
                    end
                    FUNC_ARM: begin
                        n_state = i_sts.chan_ok ? S_ARM_LD : S_IDLE;
                    end
                    FUNC_TICK: begin
                        if (i_sts.steps_zero) begin
                            n_state = S_IDLE;
                        end else begin
                            cmd.scan_clr = 1'b1;
                            n_state      = S_TICK_RD;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SET: begin
                cmd.set_wr = 1'b1;
                n_state    = S_PULSE1;
            end
            S_ARM_LD: begin
                cmd.div_start = 1'b1;
                n_state       = S_ARM_DIV;
            end
            S_ARM_DIV: begin
                if (i_sts.div_done) begin
                    cmd.arm_wr = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_TICK_RD: begin
                if (i_sts.cur_armed) begin
                    n_state = S_TICK_UPD;
                end else if (i_sts.scan_last) begin
                    n_state = S_TICK_END;
                end else begin
                    cmd.scan_inc = 1'b1;
                end
            end
            S_TICK_UPD: begin
                cmd.tick_upd = 1'b1;
                n_state      = S_PULSE1;
            end
            S_PULSE1: begin
                n_state = S_PULSE2;
            end
            S_PULSE2: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (i_sts.func != FUNC_TICK) begin
                        n_state = S_IDLE;
                    end else if (i_sts.scan_last) begin
                        n_state = S_TICK_END;
                    end else begin
                        cmd.scan_inc = 1'b1;
                        n_state      = S_TICK_RD;
                    end
                end
            end
            S_TICK_END: begin
                cmd.tick_end = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_cmd   = cmd;

endmodule

// ===== rtl/sgi_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgi_dpath
// Per-channel storage, step divider, position update, pulse arithmetic and
// the output register.
// ----------------------------------------------------------------------------
module sgi_dpath #(
    parameter int CHANNELS  = 16,
    parameter int FRAC_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sgi_pkg::t_sgi_cmd              i_cmd,
    output sgi_pkg::t_sgi_sts              o_sts,
    input  logic [sgi_pkg::FUNC_W-1:0]     i_func,
    input  logic [sgi_pkg::CHAN_W-1:0]     i_channel,
    input  logic signed [sgi_pkg::TGT_W-1:0] i_target,
    input  logic [sgi_pkg::STEP_W-1:0]     i_step_count,
    input  logic [sgi_pkg::PULSE_W-1:0]    i_pulse_min,
    input  logic [sgi_pkg::PULSE_W-1:0]    i_span_mag,
    input  logic                           i_span_neg,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [sgi_pkg::CHAN_W-1:0]     o_out_channel,
    output logic [sgi_pkg::ANGLE_W-1:0]    o_angle,
    output logic [sgi_pkg::PULSE_W-1:0]    o_pulse_width,
    output logic                           o_last
);

    import sgi_pkg::*;

    localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW   = FRAC_BITS + 9;           // position / increment width
    localparam int DW   = FRAC_BITS + ANGLE_W;     // dividend / quotient width
    localparam int DCW  = $clog2(DW + 1);
    localparam int RW   = 2 * PW + ANGLE_W;        // {position, increment, goal}
    localparam int RF_W = PROD_W - 2 + RECIP_W;

    // captured request
    logic [FUNC_W-1:0]  r_func;
    logic [CHAN_W-1:0]  r_chan;
    logic [ANGLE_W-1:0] r_tgt;
    logic [STEP_W-1:0]  r_steps;

    // channel state
    logic [STEP_W-1:0]   r_steps_left;
    logic [CHANNELS-1:0] r_armed;
    logic [CHANNELS-1:0] r_ang_vld;
    logic [CW-1:0]       r_scan;

    // step divider
    logic [DCW-1:0]     r_div_cnt;
    logic [DW-1:0]      r_dvd;
    logic [STEP_W-1:0]  r_rem;
    logic               r_div_neg;
    logic [ANGLE_W-1:0] r_start;

    // pulse pipeline
    logic [ANGLE_W-1:0] r_ang;
    logic [CHAN_W-1:0]  r_emit_ch;
    logic               r_last;
    logic [PROD_W-1:0]  r_prod;
    logic [PULSE_W-1:0] r_quot;

    // output register
    logic               r_o_valid;
    logic [CHAN_W-1:0]  r_o_ch;
    logic [ANGLE_W-1:0] r_o_angle;
    logic [PULSE_W-1:0] r_o_pulse;
    logic               r_o_last;

    logic [CW-1:0]      ch_idx;
    logic [ANGLE_W-1:0] tgt_clamped;
    logic [ANGLE_W-1:0] ang_rdata;
    logic [ANGLE_W-1:0] ang_cur;
    logic [ANGLE_W-1:0] diff_mag;
    logic               diff_neg;
    logic [STEP_W:0]    rem_sh;
    logic               rem_ge;
    logic [PW-1:0]      q_ext;
    logic [PW-1:0]      inc_new;
    logic [PW-1:0]      pos_start;

    logic [RW-1:0]      chan_rdata;
    logic [PW-1:0]      rd_pos;
    logic [PW-1:0]      rd_inc;
    logic [ANGLE_W-1:0] rd_goal;
    logic [PW+1:0]      pos_sum;
    logic [PW-1:0]      pos_next;
    logic [8:0]         pos_whole;
    logic [ANGLE_W-1:0] ang_next;
    logic               final_step;
    logic               armed_above;

    logic               ang_we;
    logic [CW-1:0]      ang_waddr;
    logic [ANGLE_W-1:0] ang_wdata;
    logic               chan_we;
    logic [CW-1:0]      chan_waddr;
    logic [RW-1:0]      chan_wdata;

    logic [RF_W-1:0]    recip_full;
    logic [PULSE_W-1:0] pulse_next;

    assign ch_idx = CW'(r_chan);

    always_comb begin
        if (i_target[TGT_W-1]) begin
            tgt_clamped = '0;
        end else if (i_target[TGT_W-2:0] > {1'b0, ANGLE_MAX}) begin
            tgt_clamped = ANGLE_MAX;
        end else begin
            tgt_clamped = i_target[ANGLE_W-1:0];
        end
    end

    // arm: signed distance from the stored angle to the goal
    assign ang_cur  = r_ang_vld[ch_idx] ? ang_rdata : ANGLE_RST;
    assign diff_neg = (r_tgt < ang_cur);
    assign diff_mag = diff_neg ? (ang_cur - r_tgt) : (r_tgt - ang_cur);

    // restoring division, one quotient bit per cycle
    assign rem_sh    = {r_rem, r_dvd[DW-1]};
    assign rem_ge    = (rem_sh >= {1'b0, r_steps});
    assign q_ext     = {1'b0, r_dvd};
    assign inc_new   = r_div_neg ? (~q_ext + 1'b1) : q_ext;
    assign pos_start = {1'b0, r_start, {FRAC_BITS{1'b0}}};

    // tick: advance one channel
    assign rd_pos     = chan_rdata[RW-1 -: PW];
    assign rd_inc     = chan_rdata[ANGLE_W +: PW];
    assign rd_goal    = chan_rdata[ANGLE_W-1:0];
    assign final_step = (r_steps_left == STEP_W'(1));
    assign pos_sum    = {2'b00, rd_pos} + {{2{rd_inc[PW-1]}}, rd_inc};

    always_comb begin
        if (final_step) begin
            pos_next = {1'b0, rd_goal, {FRAC_BITS{1'b0}}};
        end else if (pos_sum[PW+1]) begin
            pos_next = '0;
        end else if (pos_sum[PW]) begin
            pos_next = '1;
        end else begin
            pos_next = pos_sum[PW-1:0];
        end
    end

    assign pos_whole = pos_next[PW-1:FRAC_BITS];
    assign ang_next  = (pos_whole > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : pos_whole[ANGLE_W-1:0];

    always_comb begin
        armed_above = 1'b0;
        for (int j = 0; j < CHANNELS; j++) begin
            if (r_armed[j] && (j > int'(r_scan))) begin
                armed_above = 1'b1;
            end
        end
    end

    // memory write ports
    assign ang_we     = i_cmd.set_wr | i_cmd.tick_upd;
    assign ang_waddr  = i_cmd.set_wr ? ch_idx : r_scan;
    assign ang_wdata  = i_cmd.set_wr ? r_tgt : ang_next;
    assign chan_we    = i_cmd.arm_wr | i_cmd.tick_upd;
    assign chan_waddr = i_cmd.arm_wr ? ch_idx : r_scan;
    assign chan_wdata = i_cmd.arm_wr ? {pos_start, inc_new, r_tgt}
                                     : {pos_next, rd_inc, rd_goal};

    sgi_ram #(
        .WIDTH (ANGLE_W),
        .DEPTH (CHANNELS)
    ) u_ang_ram (
        .i_clk   (i_clk),
        .i_we    (ang_we),
        .i_waddr (ang_waddr),
        .i_wdata (ang_wdata),
        .i_raddr (ch_idx),
        .o_rdata (ang_rdata)
    );

    sgi_ram #(
        .WIDTH (RW),
        .DEPTH (CHANNELS)
    ) u_chan_ram (
        .i_clk   (i_clk),
        .i_we    (chan_we),
        .i_waddr (chan_waddr),
        .i_wdata (chan_wdata),
        .i_raddr (r_scan),
        .o_rdata (chan_rdata)
    );

    // pulse = min +/- angle * |span| / 180
    assign recip_full = r_prod[PROD_W-1:2] * RECIP_MUL;
    assign pulse_next = i_span_neg ? (i_pulse_min - r_quot) : (i_pulse_min + r_quot);

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_chan  <= i_channel;
            r_tgt   <= tgt_clamped;
            r_steps <= (i_step_count == '0) ? STEP_W'(1) : i_step_count;
        end
        if (i_cmd.div_start) begin
            r_dvd     <= {diff_mag, {FRAC_BITS{1'b0}}};
            r_rem     <= '0;
            r_div_neg <= diff_neg;
            r_start   <= ang_cur;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[DW-2:0], rem_ge};
            r_rem <= rem_ge ? STEP_W'(rem_sh - {1'b0, r_steps}) : rem_sh[STEP_W-1:0];
        end
        if (i_cmd.set_wr) begin
            r_ang     <= r_tgt;
            r_emit_ch <= r_chan;
            r_last    <= 1'b1;
        end else if (i_cmd.tick_upd) begin
            r_ang     <= ang_next;
            r_emit_ch <= CHAN_W'(r_scan);
            r_last    <= !armed_above;
        end
        r_prod <= r_ang * i_span_mag;
        r_quot <= recip_full[RECIP_SHIFT +: PULSE_W];
        if (i_cmd.emit) begin
            r_o_ch    <= r_emit_ch;
            r_o_angle <= r_ang;
            r_o_pulse <= pulse_next;
            r_o_last  <= r_last;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps_left <= '0;
            r_armed      <= '0;
            r_ang_vld    <= '0;
            r_scan       <= '0;
            r_div_cnt    <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cmd.set_wr) begin
                r_ang_vld[ch_idx] <= 1'b1;
            end else if (i_cmd.tick_upd) begin
                r_ang_vld[r_scan] <= 1'b1;
            end
            if (i_cmd.arm_wr) begin
                r_armed[ch_idx] <= 1'b1;
                r_steps_left    <= r_steps;
            end else if (i_cmd.tick_end) begin
                r_steps_left <= r_steps_left - 1'b1;
                if (final_step) begin
                    r_armed <= '0;
                end
            end
            if (i_cmd.scan_clr) begin
                r_scan <= '0;
            end else if (i_cmd.scan_inc) begin
                r_scan <= r_scan + 1'b1;
            end
            if (i_cmd.div_start) begin
                r_div_cnt <= DCW'(DW);
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt - 1'b1;
            end
            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_sts.func       = r_func;
    assign o_sts.chan_ok    = (int'(r_chan) < CHANNELS);
    assign o_sts.steps_zero = (r_steps_left == '0);
    assign o_sts.any_armed  = |r_armed;
    assign o_sts.cur_armed  = r_armed[r_scan];
    assign o_sts.scan_last  = (r_scan == CW'(CHANNELS - 1));
    assign o_sts.div_done   = (r_div_cnt == '0);
    assign o_sts.out_free   = !r_o_valid || i_out_ready;

    assign o_out_valid   = r_o_valid;
    assign o_out_channel = r_o_ch;
    assign o_angle       = r_o_angle;
    assign o_pulse_width = r_o_pulse;
    assign o_last        = r_o_last;

endmodule
